// ----- src/mean_value_coordinates_assert.svh -----
`ifndef MEAN_VALUE_COORDINATES_ASSERT_SVH
`define MEAN_VALUE_COORDINATES_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MVC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define MVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/mvc_pkg.sv -----
package mvc_pkg;
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned CoordBits   = 12;
  localparam logic [6:0]  CountReset  = 7'd3;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WAIT,
    ST_LEN,
    ST_TAN1,
    ST_TAN2,
    ST_DIST,
    ST_WDIV,
    ST_ACC,
    ST_NFETCH,
    ST_NWAIT,
    ST_NDIV,
    ST_EMIT
  } state_e;

  // front to back query transaction
  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [6:0]  n;
  } query_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

  // one step of an unsigned restoring integer square root over 64 bits
  function automatic logic [31:0] isqrt_step(input logic [63:0] v, input logic [31:0] r,
                                             input logic [63:0] rem, output logic [63:0] rem_o);
    logic [65:0] trial;
    trial = {rem[61:0], v[63:62]} - {32'd0, r, 2'b01};
    if (!trial[65]) begin
      rem_o = trial[63:0];
      return {r[30:0], 1'b1};
    end else begin
      rem_o = {rem[61:0], v[63:62]};
      return {r[30:0], 1'b0};
    end
  endfunction
endpackage

// ----- src/mvc_ram.sv -----
module mvc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- src/mvc_divider.sv -----
module mvc_divider (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  num_i,
  input  logic [63:0]  den_i,
  output logic         done_o,
  output logic [63:0]  quo_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [64:0] sh, diff;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    sh     = {rem_q, quo_q[63]};
    diff   = sh - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[64]) begin
        rem_d = diff[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = sh[63:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quo_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end
endmodule

// ----- src/mvc_sqrt.sv -----
module mvc_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  logic [63:0] v_q, v_d, rem_q, rem_d, rem_n;
  logic [31:0] r_q, r_d, r_n;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;

  always_comb begin
    v_d    = v_q;
    rem_d  = rem_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    r_n    = mvc_pkg::isqrt_step(v_q, r_q, rem_q, rem_n);
    if (start_i) begin
      v_d    = val_i;
      rem_d  = '0;
      r_d    = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      v_d   = {v_q[61:0], 2'b00};
      rem_d = rem_n;
      r_d   = r_n;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign root_o = r_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    rem_q <= rem_d;
    r_q   <= r_d;
  end
endmodule

// ----- src/mvc_front.sv -----
module mvc_front #(
  parameter int unsigned MaxVertices = mvc_pkg::MaxVertices,
  parameter int unsigned CoordBits   = mvc_pkg::CoordBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           back_idle_i,
  input  logic                           command_i,
  input  logic [5:0]                     vertex_index_i,
  input  logic [11:0]                    point_x_i,
  input  logic [11:0]                    point_y_i,
  input  logic                           vertex_enable_i,
  input  logic                           cfg_we_i,
  input  logic [6:0]                     cfg_wdata_i,
  output logic                           vx_we_o,
  output logic [$clog2(MaxVertices)-1:0] vx_waddr_o,
  output logic [2*CoordBits:0]           vx_wdata_o,
  output logic [MaxVertices-1:0]         enable_o,
  output mvc_pkg::query_t                query_o,
  output mvc_pkg::hs_t                   q_hs_o,
  input  logic                           q_ready_i
);
  localparam int unsigned IdxW = $clog2(MaxVertices);

  logic [6:0]             count_q;
  logic [MaxVertices-1:0] enable_q;
  logic                   full_q;
  mvc_pkg::query_t        slot_q;
  logic                   accept, is_load, in_range;
  logic [6:0]             n_clamped;
  logic [CoordBits-1:0]   px, py;

  assign busy_o   = full_q || !back_idle_i;
  assign accept   = start_i && !busy_o;
  assign is_load  = (mvc_pkg::cmd_e'(command_i) == mvc_pkg::CMD_LOAD);
  assign in_range = ({1'b0, vertex_index_i} < 7'(MaxVertices));
  assign px       = point_x_i[CoordBits-1:0];
  assign py       = point_y_i[CoordBits-1:0];

  always_comb begin
    n_clamped = count_q;
    if (count_q < 7'd3) n_clamped = 7'd3;
    if (count_q > 7'(MaxVertices)) n_clamped = 7'(MaxVertices);
  end

  assign vx_we_o    = accept && is_load && in_range;
  assign vx_waddr_o = vertex_index_i[IdxW-1:0];
  assign vx_wdata_o = {vertex_enable_i, py, px};
  assign enable_o   = enable_q;
  assign query_o    = slot_q;
  assign q_hs_o     = '{valid: full_q, ready: q_ready_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= mvc_pkg::CountReset;
      enable_q <= '1;
      full_q   <= 1'b0;
    end else begin
      if (cfg_we_i) count_q <= cfg_wdata_i;
      if (vx_we_o) enable_q[vertex_index_i[IdxW-1:0]] <= vertex_enable_i;
      if (full_q && q_ready_i) full_q <= 1'b0;
      else if (accept && !is_load) full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_load) begin
      slot_q.px <= 16'(px);
      slot_q.py <= 16'(py);
      slot_q.n  <= n_clamped;
    end
  end
endmodule

// ----- src/mvc_back.sv -----
module mvc_back #(
  parameter int unsigned MaxVertices = mvc_pkg::MaxVertices,
  parameter int unsigned CoordBits   = mvc_pkg::CoordBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mvc_pkg::query_t                query_i,
  input  mvc_pkg::hs_t                   q_hs_i,
  output logic                           q_ready_o,
  input  logic                           vx_we_i,
  input  logic [$clog2(MaxVertices)-1:0] vx_waddr_i,
  input  logic [2*CoordBits:0]           vx_wdata_i,
  input  logic [MaxVertices-1:0]         enable_i,
  output logic                           idle_o,
  output logic                           done_o,
  output logic [5:0]                     weight_index_o,
  output logic signed [31:0]             coordinate_o,
  output logic                           last_o,
  output logic                           zero_sum_o
);
  localparam int unsigned IdxW = $clog2(MaxVertices);
  localparam logic [63:0] HMax = 64'd2147483647;
  localparam logic [63:0] WMax = 64'd549755813887;

  mvc_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] i_q, i_d, rd_addr;
  logic [1:0]      sub_q, sub_d;
  logic [6:0]      n_q, n_d;
  logic [15:0]     px_q, py_q;
  logic signed [17:0] dx_q [3], dy_q [3];
  logic [31:0]     len_q [3];
  logic signed [63:0] hs_q, hs_d, sum_q, sum_d, w_q, w_d;
  logic [IdxW-1:0] addr_q, addr_d;
  logic [2*CoordBits:0] vx_rdata;
  logic [39:0]     w_rdata;
  logic            w_we;

  logic        sq_start, sq_done;
  logic [63:0] sq_val;
  logic [31:0] sq_root;
  logic        dv_start, dv_done;
  logic [63:0] dv_num, dv_den, dv_quo;

  logic signed [17:0] ux, uy, vx, vy;
  logic signed [36:0] cr, dt;
  logic [63:0]        lprod;
  logic signed [63:0] den;
  logic [63:0]        crmag, tmag;
  logic [1:0]         ua, ub;
  logic               load_vec, dot_phase;
  logic signed [17:0] nx, ny;
  logic [IdxW-1:0]    prev_i, next_i, last_i;
  logic signed [63:0] hval;
  logic [63:0]        q_sat;

  mvc_ram #(.Width(2*CoordBits+1), .Depth(MaxVertices)) u_vx_ram (
    .clk_i, .we_i(vx_we_i), .waddr_i(vx_waddr_i), .wdata_i(vx_wdata_i),
    .raddr_i(rd_addr), .rdata_o(vx_rdata)
  );

  mvc_ram #(.Width(40), .Depth(MaxVertices)) u_w_ram (
    .clk_i, .we_i(w_we), .waddr_i(i_q), .wdata_i(w_q[39:0]),
    .raddr_i(rd_addr), .rdata_o(w_rdata)
  );

  mvc_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .val_i(sq_val), .done_o(sq_done), .root_o(sq_root)
  );

  mvc_divider u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  assign last_i = IdxW'(n_q - 7'd1);
  assign prev_i = (i_q == '0) ? last_i : i_q - IdxW'(1);
  assign next_i = (i_q == last_i) ? '0 : i_q + IdxW'(1);
  assign nx = 18'(vx_rdata[CoordBits-1:0]) - 18'(px_q);
  assign ny = 18'(vx_rdata[2*CoordBits-1:CoordBits]) - 18'(py_q);

  // tangent operand select: sub 0 is (a,b), sub 1 is (b,c)
  always_comb begin
    ua = sub_q;
    ub = sub_q + 2'd1;
    ux = dx_q[ua];
    uy = dy_q[ua];
    vx = dx_q[ub];
    vy = dy_q[ub];
    cr = 37'(ux) * 37'(vy) - 37'(uy) * 37'(vx);
    dt = 37'(ux) * 37'(vx) + 37'(uy) * 37'(vy);
    lprod = len_q[ua] * len_q[ub];
    den = $signed(lprod) + 64'(dt) * 64'sd16384;
    crmag = cr[36] ? 64'(-cr) : 64'(cr);
    tmag = (dv_quo > HMax) ? HMax : dv_quo;
    if (den <= 0) begin
      if (cr > 0) hval = -$signed(HMax);
      else if (cr < 0) hval = $signed(HMax);
      else hval = (dt < 0) ? $signed(HMax) : 64'sd0;
    end else begin
      hval = (cr > 0) ? -$signed(tmag) : $signed(tmag);
    end
  end

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    sub_d     = sub_q;
    n_d       = n_q;
    hs_d      = hs_q;
    sum_d     = sum_q;
    w_d       = w_q;
    addr_d    = addr_q;
    rd_addr   = addr_q;
    q_ready_o = 1'b0;
    sq_start  = 1'b0;
    sq_val    = '0;
    dv_start  = 1'b0;
    dv_num    = '0;
    dv_den    = 64'd1;
    w_we      = 1'b0;
    done_o    = 1'b0;
    load_vec  = 1'b0;
    dot_phase = 1'b0;
    q_sat     = '0;
    unique case (state_q)
      mvc_pkg::ST_IDLE: begin
        if (q_hs_i.valid) begin
          q_ready_o = 1'b1;
          n_d       = query_i.n;
          i_d       = '0;
          sum_d     = '0;
          state_d   = mvc_pkg::ST_FETCH;
        end
      end
      mvc_pkg::ST_FETCH: begin
        if (!enable_i[i_q]) begin
          w_d     = '0;
          state_d = mvc_pkg::ST_ACC;
        end else begin
          sub_d   = 2'd0;
          rd_addr = prev_i;
          addr_d  = prev_i;
          state_d = mvc_pkg::ST_WAIT;
        end
      end
      mvc_pkg::ST_WAIT: begin
        load_vec = 1'b1;
        sq_start = 1'b1;
        sq_val   = 64'(nx * nx + ny * ny) << 14;
        state_d  = mvc_pkg::ST_LEN;
      end
      mvc_pkg::ST_LEN: begin
        if (sq_done) begin
          if (sub_q == 2'd2) begin
            sub_d   = 2'd0;
            state_d = mvc_pkg::ST_TAN1;
          end else begin
            sub_d   = sub_q + 2'd1;
            rd_addr = (sub_q == 2'd0) ? i_q : next_i;
            addr_d  = rd_addr;
            state_d = mvc_pkg::ST_WAIT;
          end
        end
      end
      mvc_pkg::ST_TAN1: begin
        dv_start = 1'b1;
        dv_num   = crmag << 30;
        dv_den   = (den > 0) ? den : 64'd1;
        state_d  = mvc_pkg::ST_TAN2;
      end
      mvc_pkg::ST_TAN2: begin
        if (dv_done) begin
          if (sub_q == 2'd0) begin
            hs_d    = hval;
            sub_d   = 2'd1;
            state_d = mvc_pkg::ST_TAN1;
          end else begin
            hs_d     = hs_q + hval;
            sq_start = 1'b1;
            sq_val   = 64'(dx_q[1] * dx_q[1] + dy_q[1] * dy_q[1]) << 20;
            state_d  = mvc_pkg::ST_DIST;
          end
        end
      end
      mvc_pkg::ST_DIST: begin
        if (sq_done) begin
          dv_start = 1'b1;
          dv_num   = (hs_q[63] ? 64'(-hs_q) : 64'(hs_q)) << 18;
          dv_den   = 64'(sq_root) + 64'd1;
          state_d  = mvc_pkg::ST_WDIV;
        end
      end
      mvc_pkg::ST_WDIV: begin
        if (dv_done) begin
          q_sat   = (dv_quo > WMax) ? WMax : dv_quo;
          w_d     = hs_q[63] ? -$signed(q_sat) : $signed(q_sat);
          state_d = mvc_pkg::ST_ACC;
        end
      end
      mvc_pkg::ST_ACC: begin
        w_we  = 1'b1;
        sum_d = sum_q + w_q;
        if (i_q == last_i) begin
          i_d     = '0;
          state_d = mvc_pkg::ST_NFETCH;
        end else begin
          i_d     = i_q + IdxW'(1);
          state_d = mvc_pkg::ST_FETCH;
        end
      end
      mvc_pkg::ST_NFETCH: begin
        rd_addr = i_q;
        addr_d  = i_q;
        state_d = mvc_pkg::ST_NWAIT;
      end
      mvc_pkg::ST_NWAIT: begin
        w_d = 64'($signed(w_rdata));
        if (sum_q == 0) begin
          state_d = mvc_pkg::ST_EMIT;
        end else begin
          dv_start = 1'b1;
          dv_num   = (w_rdata[39] ? 64'(-$signed(w_rdata)) : 64'(w_rdata)) << 24;
          dv_den   = sum_q[63] ? 64'(-sum_q) : 64'(sum_q);
          state_d  = mvc_pkg::ST_NDIV;
        end
      end
      mvc_pkg::ST_NDIV: begin
        if (dv_done) begin
          if (w_q[63] != sum_q[63]) begin
            q_sat = (dv_quo > 64'h8000_0000) ? 64'h8000_0000 : dv_quo;
            w_d   = -$signed(q_sat);
          end else begin
            q_sat = (dv_quo > 64'h7fff_ffff) ? 64'h7fff_ffff : dv_quo;
            w_d   = $signed(q_sat);
          end
          state_d = mvc_pkg::ST_EMIT;
        end
      end
      mvc_pkg::ST_EMIT: begin
        done_o = 1'b1;
        if (i_q == last_i) begin
          state_d = mvc_pkg::ST_IDLE;
        end else begin
          i_d     = i_q + IdxW'(1);
          state_d = mvc_pkg::ST_NFETCH;
        end
      end
      default: state_d = mvc_pkg::ST_IDLE;
    endcase
  end

  assign idle_o         = (state_q == mvc_pkg::ST_IDLE);
  assign weight_index_o = 6'(i_q);
  assign coordinate_o   = (sum_q == 0) ? 32'sd0 : w_q[31:0];
  assign last_o         = (i_q == last_i);
  assign zero_sum_o     = (sum_q == 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mvc_pkg::ST_IDLE;
      i_q     <= '0;
      sub_q   <= '0;
      n_q     <= 7'd3;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      sub_q   <= sub_d;
      n_q     <= n_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hs_q   <= hs_d;
    w_q    <= w_d;
    addr_q <= addr_d;
    if (state_q == mvc_pkg::ST_IDLE && q_hs_i.valid) begin
      px_q <= query_i.px;
      py_q <= query_i.py;
    end
    if (load_vec) begin
      dx_q[sub_q] <= nx;
      dy_q[sub_q] <= ny;
    end
    if (state_q == mvc_pkg::ST_LEN && sq_done) len_q[sub_q] <= sq_root;
  end
endmodule

// ----- src/mean_value_coordinates.sv -----
// Mean value coordinates of a point inside a closed boundary polygon of up to
// MaxVertices vertices. start with command_i = 0 loads one vertex (no result);
// with command_i = 1 it queries a point, and one result per vertex in use then
// comes out on done_o, vertex 0 first, last_o on the final one. The receiver
// cannot stall: each result is shown for one cycle only. A query is registered
// in a one-entry queue before the back end takes it; busy is high while that
// entry is occupied or the back end works, so nothing is accepted until the
// last result of a query is out. For each enabled vertex the back end does a
// fetch, three length steps, two tangent divisions, a distance root, a weight
// division and an accumulate; a disabled vertex gets only the fetch and the
// accumulate. Then each vertex is normalized in turn. One shared 64-step
// restoring divider and one 32-step square root unit serve every vertex in
// turn (four roots and three divisions per enabled vertex, one division per
// normalized vertex, none when the sum is zero). Configure only when idle.
module mean_value_coordinates #(
  parameter int unsigned MaxVertices = mvc_pkg::MaxVertices,
  parameter int unsigned CoordBits   = mvc_pkg::CoordBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic [5:0]         vertex_index_i,
  input  logic [11:0]        point_x_i,
  input  logic [11:0]        point_y_i,
  input  logic               vertex_enable_i,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_wdata_i,
  output logic               done_o,
  output logic [5:0]         weight_index_o,
  output logic signed [31:0] coordinate_o,
  output logic               last_o,
  output logic               zero_sum_o
);
  logic                           vx_we;
  logic [$clog2(MaxVertices)-1:0] vx_waddr;
  logic [2*CoordBits:0]           vx_wdata;
  logic [MaxVertices-1:0]         enable;
  mvc_pkg::query_t                query;
  mvc_pkg::hs_t                   q_hs;
  logic                           q_ready, back_idle, front_busy;

  assign busy = front_busy;

  mvc_front #(.MaxVertices(MaxVertices), .CoordBits(CoordBits)) u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_o(front_busy), .back_idle_i(back_idle),
    .command_i, .vertex_index_i, .point_x_i, .point_y_i, .vertex_enable_i,
    .cfg_we_i, .cfg_wdata_i,
    .vx_we_o(vx_we), .vx_waddr_o(vx_waddr), .vx_wdata_o(vx_wdata), .enable_o(enable),
    .query_o(query), .q_hs_o(q_hs), .q_ready_i(q_ready)
  );

  mvc_back #(.MaxVertices(MaxVertices), .CoordBits(CoordBits)) u_back (
    .clk_i, .rst_ni, .query_i(query), .q_hs_i(q_hs), .q_ready_o(q_ready),
    .vx_we_i(vx_we), .vx_waddr_i(vx_waddr), .vx_wdata_i(vx_wdata), .enable_i(enable),
    .idle_o(back_idle), .done_o, .weight_index_o, .coordinate_o, .last_o, .zero_sum_o
  );
endmodule

// ----- src/mvc_checker.sv -----
`include "mean_value_coordinates_assert.svh"
module mvc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       command_i,
  input logic       done_o,
  input logic [5:0] weight_index_o,
  input logic       last_o,
  input logic       zero_sum_o
);
  `MVC_ASSERT_IMPL(a_no_result_when_free, done_o, busy)
  `MVC_ASSERT_NEXT(a_query_busy, start && !busy && command_i, busy)
  `MVC_ASSERT_NEXT(a_index_steps, done_o && !last_o, !done_o || weight_index_o != 6'd0)
  `MVC_ASSERT_NEXT(a_zero_sum_stable, done_o && !last_o, !done_o || $stable(zero_sum_o))
endmodule

bind mean_value_coordinates mvc_checker u_checker (
  .clk_i, .rst_ni, .start, .busy, .command_i, .done_o, .weight_index_o, .last_o, .zero_sum_o
);
